>>> sv/bct_pkg.sv
// shared types, codes and constants of the button countdown timer
`default_nettype none
package bct_pkg;

   localparam int unsigned SecondsWidth = 16;
   localparam int unsigned HoldWidth    = 10;
   localparam int unsigned CsrIdxWidth  = 3;

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_HOLDOFF = 2'd1;
   localparam logic [1:0] MODE_RUNNING = 2'd2;

   localparam logic [1:0] EVENT_NONE   = 2'd0;
   localparam logic [1:0] EVENT_ALARM  = 2'd1;
   localparam logic [1:0] EVENT_CANCEL = 2'd2;

   localparam logic [CsrIdxWidth-1:0] REG_TICKS_PER_SECOND  = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_LED_PULSE_TICKS   = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_DEBOUNCE_TICKS    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_SHORT_ADD_SECONDS = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_LONG_ADD_SECONDS  = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_CANCEL_HOLD_TICKS = 3'd5;
   localparam logic [CsrIdxWidth-1:0] REG_HOLDOFF_TICKS     = 3'd6;

   typedef struct packed {
      logic [7:0]              ticks_per_second;
      logic [7:0]              led_pulse_ticks;
      logic [7:0]              debounce_ticks;
      logic [SecondsWidth-1:0] short_add_seconds;
      logic [SecondsWidth-1:0] long_add_seconds;
      logic [HoldWidth-1:0]    cancel_hold_ticks;
      logic [7:0]              holdoff_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic [7:0]              prescale_count;
      logic [SecondsWidth-1:0] seconds_count;
      logic [7:0]              debounce_count;
      logic [HoldWidth-1:0]    hold_count;
      logic [7:0]              holdoff_count;
      logic [1:0]              last_levels;
      logic                    led_state;
   } state_type;

   typedef struct packed {
      logic                    led;
      logic [1:0]              event_res;
      logic [SecondsWidth-1:0] seconds_left;
      logic                    is_armed;
   } result_type;

   // saturating add of two second counts
   function automatic logic [SecondsWidth-1:0] sat_add(input logic [SecondsWidth-1:0] a,
                                                       input logic [SecondsWidth-1:0] b);
      logic [SecondsWidth:0] sum;
      begin
         sum = {1'b0, a} + {1'b0, b};
         sat_add = sum[SecondsWidth] ? {SecondsWidth{1'b1}} : sum[SecondsWidth-1:0];
      end
   endfunction

endpackage
`default_nettype wire

>>> sv/bct_ifs.sv
// handshake channel interfaces for requests, results and register writes
`default_nettype none
interface bct_req_if;
   logic valid;
   logic ready;
   logic button_short;
   logic button_long;
   modport source (output valid, output button_short, output button_long, input ready);
   modport sink   (input valid, input button_short, input button_long, output ready);
endinterface

interface bct_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             led;
   logic [1:0]                       event_res;
   logic [bct_pkg::SecondsWidth-1:0] seconds_left;
   logic                             is_armed;
   modport source (output valid, output led, output event_res, output seconds_left,
                   output is_armed, input ready);
   modport sink   (input valid, input led, input event_res, input seconds_left,
                   input is_armed, output ready);
endinterface

interface bct_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bct_pkg::CsrIdxWidth-1:0] index;
   logic [15:0]                     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> sv/bct_step.sv
// next-state and result logic for one tick
`default_nettype none
module bct_step
   import bct_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  cur,
   input  logic [1:0] levels,
   output state_type  nxt,
   output result_type res
);

   logic [7:0] pre_inc;
   logic       active;

   always_comb begin
      nxt           = cur;
      res.event_res = EVENT_NONE;
      active        = (cur.mode == MODE_HOLDOFF) || (cur.mode == MODE_RUNNING);
      pre_inc       = cur.prescale_count + 8'd1;

      // button edges: add time and arm from idle
      if (levels != cur.last_levels) begin
         if (cur.debounce_count == 8'd0 && levels != 2'b00) begin
            if (levels[0]) nxt.seconds_count = sat_add(nxt.seconds_count, cfg.short_add_seconds);
            if (levels[1]) nxt.seconds_count = sat_add(nxt.seconds_count, cfg.long_add_seconds);
            if (!active) begin
               nxt.mode           = MODE_HOLDOFF;
               nxt.prescale_count = '0;
               nxt.holdoff_count  = '0;
               nxt.hold_count     = '0;
            end
         end
         nxt.debounce_count = cfg.debounce_ticks;
         nxt.last_levels    = levels;
      end else if (cur.debounce_count != 8'd0) begin
         nxt.debounce_count = cur.debounce_count - 8'd1;
      end

      if (active) begin
         nxt.prescale_count = pre_inc;
         if (pre_inc >= cfg.ticks_per_second) begin
            nxt.prescale_count = '0;
            if (nxt.seconds_count != '0) nxt.seconds_count = nxt.seconds_count - 16'd1;
            nxt.led_state = 1'b1;
         end
         if (nxt.prescale_count == cfg.led_pulse_ticks) nxt.led_state = 1'b0;

         if (cur.mode == MODE_HOLDOFF) begin
            if (cur.holdoff_count >= cfg.holdoff_ticks) begin
               nxt.mode       = MODE_RUNNING;
               nxt.hold_count = '0;
            end else begin
               nxt.holdoff_count = cur.holdoff_count + 8'd1;
            end
         end else begin
            if (nxt.seconds_count == '0) begin
               res.event_res = EVENT_ALARM;
            end else begin
               if (levels != 2'b00) begin
                  if (nxt.hold_count != {HoldWidth{1'b1}})
                     nxt.hold_count = nxt.hold_count + 10'd1;
               end else begin
                  nxt.hold_count = '0;
               end
               if (nxt.hold_count >= cfg.cancel_hold_ticks) res.event_res = EVENT_CANCEL;
            end
            // end of run
            if (res.event_res != EVENT_NONE) begin
               nxt.seconds_count  = '0;
               nxt.debounce_count = '0;
               nxt.hold_count     = '0;
               nxt.led_state      = 1'b0;
               nxt.mode           = MODE_IDLE;
            end
         end
      end

      res.led          = nxt.led_state;
      res.seconds_left = nxt.seconds_count;
      res.is_armed     = (nxt.mode == MODE_HOLDOFF) || (nxt.mode == MODE_RUNNING);
   end

endmodule
`default_nettype wire

>>> sv/button_countdown_timer_top.sv
// top level of the button countdown timer: registers, state and result stage
`default_nettype none
// One request beat is one timer tick with the two button levels; every tick gives exactly
// one result beat (LED, event, seconds left, armed flag) in the cycle after it is taken.
// A new tick can be taken in every cycle unless the result side stalls: the state registers
// update in the same cycle the beat is accepted, and the result register frees itself
// whenever the sink takes its beat, so the sustained rate is one tick per clock and stalls
// come only from the result side. Register writes are always accepted, as ready is tied
// high, and must only happen while no tick is in flight.
module button_countdown_timer_top
   import bct_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   bct_req_if.sink   req_bus,
   bct_rsp_if.source rsp_bus,
   bct_csr_if.sink   csr_bus
);

   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_nxt;
   result_type res_ff, res_nxt;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_TICKS_PER_SECOND:  cfg_in.ticks_per_second  = csr_bus.data[7:0];
            REG_LED_PULSE_TICKS:   cfg_in.led_pulse_ticks   = csr_bus.data[7:0];
            REG_DEBOUNCE_TICKS:    cfg_in.debounce_ticks    = csr_bus.data[7:0];
            REG_SHORT_ADD_SECONDS: cfg_in.short_add_seconds = csr_bus.data;
            REG_LONG_ADD_SECONDS:  cfg_in.long_add_seconds  = csr_bus.data;
            REG_CANCEL_HOLD_TICKS: cfg_in.cancel_hold_ticks = csr_bus.data[HoldWidth-1:0];
            REG_HOLDOFF_TICKS:     cfg_in.holdoff_ticks     = csr_bus.data[7:0];
            default: ;
         endcase
      end
   end

   bct_step u_step (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .levels ({req_bus.button_long, req_bus.button_short}),
      .nxt    (state_nxt),
      .res    (res_nxt)
   );

   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_second  <= 8'd125;
         cfg_ff.led_pulse_ticks   <= 8'd2;
         cfg_ff.debounce_ticks    <= 8'd2;
         cfg_ff.short_add_seconds <= 16'd60;
         cfg_ff.long_add_seconds  <= 16'd600;
         cfg_ff.cancel_hold_ticks <= 10'd188;
         cfg_ff.holdoff_ticks     <= 8'd125;
         state_ff.mode            <= MODE_IDLE;
         state_ff.prescale_count  <= '0;
         state_ff.seconds_count   <= '0;
         state_ff.debounce_count  <= '0;
         state_ff.hold_count      <= '0;
         state_ff.holdoff_count   <= '0;
         state_ff.last_levels     <= '0;
         state_ff.led_state       <= 1'b0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) state_ff <= state_nxt;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      if (req_take) res_ff <= res_nxt;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.led          = res_ff.led;
   assign rsp_bus.event_res    = res_ff.event_res;
   assign rsp_bus.seconds_left = res_ff.seconds_left;
   assign rsp_bus.is_armed     = res_ff.is_armed;

endmodule
`default_nettype wire

>>> sv/bct_checker.sv
// port-level checks of the button countdown timer and their bind
`default_nettype none
module bct_checker
   import bct_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    rsp_led,
   input wire logic [1:0]              rsp_event_res,
   input wire logic [SecondsWidth-1:0] rsp_seconds_left,
   input wire logic                    rsp_is_armed
);

   // a stalled result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_seconds_left) && $stable(rsp_is_armed) && $stable(rsp_led))
      else $error("result beat changed while stalled");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res != 2'd3)
      else $error("undefined event code");

   // a run that ends leaves the timer idle, dark and at zero
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EVENT_ALARM || rsp_event_res == EVENT_CANCEL)
         |-> !rsp_is_armed && !rsp_led && rsp_seconds_left == '0)
      else $error("run ended with state left over");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid after reset");

endmodule

bind button_countdown_timer_top bct_checker u_bct_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_led          (rsp_bus.led),
   .rsp_event_res    (rsp_bus.event_res),
   .rsp_seconds_left (rsp_bus.seconds_left),
   .rsp_is_armed     (rsp_bus.is_armed)
);
`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench of the button countdown timer: tick stimulus, predictor, checker
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bct_pkg::*;

   localparam logic [CsrIdxWidth-1:0] REG_NONE = 3'd7;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned ITEM_TARGET = 1525;
   localparam int unsigned MAX_WAIT_TICKS = 300;

   typedef struct packed {
      logic short_pressed;
      logic long_pressed;
   } buttons_type;

   logic clock;
   logic reset;

   bct_req_if req_bus();
   bct_rsp_if rsp_bus();
   bct_csr_if csr_bus();

   button_countdown_timer_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // shadow registers and timer state of the predictor
   cfg_type   cfg;
   state_type tmr;

   buttons_type level_q[$];
   result_type  timer_out_q[$];
   buttons_type next_levels;
   int unsigned queued;
   int unsigned err_count;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned idle_cycles;
   bit          calm;

   always #6 clock = ~clock;

   function automatic int unsigned pick_pause();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SecondsWidth-1:0] sat_seconds(input logic [SecondsWidth-1:0] base,
                                                           input logic [SecondsWidth-1:0] amount);
      logic [SecondsWidth:0] sum;
      sum = {1'b0, base} + {1'b0, amount};
      return sum[SecondsWidth] ? {SecondsWidth{1'b1}} : sum[SecondsWidth-1:0];
   endfunction

   function automatic void end_countdown();
      tmr.seconds_count  = '0;
      tmr.debounce_count = '0;
      tmr.hold_count     = '0;
      tmr.led_state      = 1'b0;
      tmr.mode           = MODE_IDLE;
   endfunction

   function automatic void set_shadow_reg(input logic [CsrIdxWidth-1:0] idx,
                                          input logic [15:0] value);
      case (idx)
         REG_TICKS_PER_SECOND:  cfg.ticks_per_second  = value[7:0];
         REG_LED_PULSE_TICKS:   cfg.led_pulse_ticks   = value[7:0];
         REG_DEBOUNCE_TICKS:    cfg.debounce_ticks    = value[7:0];
         REG_SHORT_ADD_SECONDS: cfg.short_add_seconds = value;
         REG_LONG_ADD_SECONDS:  cfg.long_add_seconds  = value;
         REG_CANCEL_HOLD_TICKS: cfg.cancel_hold_ticks = value[HoldWidth-1:0];
         REG_HOLDOFF_TICKS:     cfg.holdoff_ticks     = value[7:0];
         default: ;
      endcase
   endfunction

   // one tick of the timer: updates tmr and returns the result beat it gives
   function automatic result_type step_timer(input logic btn_s, input logic btn_l);
      logic [1:0] levels;
      logic [1:0] start_mode;
      logic [1:0] evt;
      result_type res;
      levels     = {btn_l, btn_s};
      start_mode = tmr.mode;
      evt        = EVENT_NONE;

      if (levels != tmr.last_levels) begin
         if (tmr.debounce_count == 0 && levels != 2'b00) begin
            if (btn_s) tmr.seconds_count = sat_seconds(tmr.seconds_count, cfg.short_add_seconds);
            if (btn_l) tmr.seconds_count = sat_seconds(tmr.seconds_count, cfg.long_add_seconds);
            if (tmr.mode != MODE_HOLDOFF && tmr.mode != MODE_RUNNING) begin
               tmr.mode           = MODE_HOLDOFF;
               tmr.prescale_count = '0;
               tmr.holdoff_count  = '0;
               tmr.hold_count     = '0;
            end
         end
         tmr.debounce_count = cfg.debounce_ticks;
         tmr.last_levels    = levels;
      end else if (tmr.debounce_count != 0) begin
         tmr.debounce_count = tmr.debounce_count - 8'd1;
      end

      // a timer armed on this tick starts counting on the next one
      if (start_mode == MODE_HOLDOFF || start_mode == MODE_RUNNING) begin
         tmr.prescale_count = tmr.prescale_count + 8'd1;
         if (tmr.prescale_count >= cfg.ticks_per_second) begin
            tmr.prescale_count = '0;
            if (tmr.seconds_count != 0) tmr.seconds_count = tmr.seconds_count - 16'd1;
            tmr.led_state = 1'b1;
         end
         if (tmr.prescale_count == cfg.led_pulse_ticks) tmr.led_state = 1'b0;

         if (start_mode == MODE_HOLDOFF) begin
            if (tmr.holdoff_count >= cfg.holdoff_ticks) begin
               tmr.mode       = MODE_RUNNING;
               tmr.hold_count = '0;
            end else begin
               tmr.holdoff_count = tmr.holdoff_count + 8'd1;
            end
         end else if (tmr.seconds_count == 0) begin
            evt = EVENT_ALARM;
            end_countdown();
         end else begin
            if (levels != 2'b00) begin
               if (tmr.hold_count != {HoldWidth{1'b1}}) tmr.hold_count = tmr.hold_count + 10'd1;
            end else begin
               tmr.hold_count = '0;
            end
            if (tmr.hold_count >= cfg.cancel_hold_ticks) begin
               evt = EVENT_CANCEL;
               end_countdown();
            end
         end
      end

      res.led          = tmr.led_state;
      res.event_res    = evt;
      res.seconds_left = tmr.seconds_count;
      res.is_armed     = (tmr.mode == MODE_HOLDOFF || tmr.mode == MODE_RUNNING);
      return res;
   endfunction

   task automatic flag_error(input string msg);
      err_count++;
      if (err_count <= 10) $display("tb_top: %s", msg);
   endtask

   // driver: one tick beat per handshake, random gaps between beats
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            timer_out_q.push_back(step_timer(req_bus.button_short, req_bus.button_long));
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (level_q.size() != 0) begin
               next_levels = level_q.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.button_short <= next_levels.short_pressed;
               req_bus.button_long  <= next_levels.long_pressed;
               gap_left = pick_pause();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure and field-by-field check of each result beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (timer_out_q.size() == 0) begin
               flag_error("result beat with nothing expected");
            end else begin
               result_type want;
               want = timer_out_q.pop_front();
               if (rsp_bus.led !== want.led)
                  flag_error($sformatf("led: expected %0d, got %0d", want.led, rsp_bus.led));
               if (rsp_bus.event_res !== want.event_res)
                  flag_error($sformatf("event_res: expected %0d, got %0d",
                                       want.event_res, rsp_bus.event_res));
               if (rsp_bus.seconds_left !== want.seconds_left)
                  flag_error($sformatf("seconds_left: expected %0d, got %0d",
                                       want.seconds_left, rsp_bus.seconds_left));
               if (rsp_bus.is_armed !== want.is_armed)
                  flag_error($sformatf("is_armed: expected %0d, got %0d",
                                       want.is_armed, rsp_bus.is_armed));
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall_left = pick_pause();
            rsp_bus.ready <= (stall_left == 0);
            if (stall_left != 0) stall_left--;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      set_shadow_reg(idx, value);
      csr_bus.valid <= 1'b0;
   endtask

   // now and then set the bits above the register width, which must be dropped
   function automatic logic [15:0] with_junk(input logic [15:0] value, input int unsigned w);
      logic [15:0] upper;
      upper = 16'hFFFF << w;
      if ($urandom_range(0, 7) == 0) return value | (16'($urandom) & upper);
      return value;
   endfunction

   task automatic choose_settings();
      int unsigned r;
      r = $urandom_range(0, 99);
      write_reg(REG_TICKS_PER_SECOND, with_junk(16'(r < 5 ? 0 : r < 10 ? 255 : r < 20 ? 1 :
                                                $urandom_range(2, 6)), 8));
      r = $urandom_range(0, 99);
      write_reg(REG_LED_PULSE_TICKS, with_junk(16'(r < 5 ? 0 : r < 10 ? 255 :
                                               $urandom_range(1, 7)), 8));
      r = $urandom_range(0, 99);
      write_reg(REG_DEBOUNCE_TICKS, with_junk(16'(r < 25 ? 0 : r < 29 ? 255 :
                                              $urandom_range(1, 4)), 8));
      r = $urandom_range(0, 99);
      write_reg(REG_SHORT_ADD_SECONDS, 16'(r < 8 ? 0 : r < 13 ? 65535 : $urandom_range(1, 4)));
      r = $urandom_range(0, 99);
      write_reg(REG_LONG_ADD_SECONDS, 16'(r < 8 ? 0 : r < 13 ? 65535 : $urandom_range(1, 8)));
      r = $urandom_range(0, 99);
      write_reg(REG_CANCEL_HOLD_TICKS, with_junk(16'(r < 4 ? 0 : r < 7 ? 1023 : r < 15 ? 1 :
                                                 $urandom_range(2, 12)), HoldWidth));
      r = $urandom_range(0, 99);
      write_reg(REG_HOLDOFF_TICKS, with_junk(16'(r < 10 ? 0 : r < 14 ? 255 :
                                             $urandom_range(1, 8)), 8));
   endtask

   task automatic queue_levels(input logic s, input logic l, input int unsigned n);
      buttons_type b;
      b.short_pressed = s;
      b.long_pressed  = l;
      repeat (n) level_q.push_back(b);
      queued += n;
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(5, 20))
         queue_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom_range(1, 3));
   endtask

   // press to arm, maybe top up, then let it expire, hold to cancel or scramble
   task automatic queue_run();
      logic        s;
      logic        l;
      int unsigned per_sec;
      int unsigned add;
      int unsigned wait_ticks;
      int unsigned ending;
      ending = $urandom_range(0, 2);
      s = 1'($urandom_range(0, 1));
      l = s ? 1'($urandom_range(0, 1)) : 1'b1;
      per_sec = (cfg.ticks_per_second == 0) ? 1 : cfg.ticks_per_second;
      add = (s ? cfg.short_add_seconds : 0) + (l ? cfg.long_add_seconds : 0);
      queue_levels(s, l, $urandom_range(1, 4));
      queue_levels(1'b0, 1'b0, $urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) begin
         queue_levels(1'($urandom_range(0, 1)), 1'b1, $urandom_range(1, 3));
         queue_levels(1'b0, 1'b0, $urandom_range(1, 3));
      end
      case (ending)
         0: begin
            wait_ticks = cfg.holdoff_ticks + 3 + per_sec * (add + 1);
            if (wait_ticks > MAX_WAIT_TICKS) wait_ticks = MAX_WAIT_TICKS;
            queue_levels(1'b0, 1'b0, wait_ticks);
         end
         1: begin
            queue_levels(1'b0, 1'b0, cfg.holdoff_ticks + 2);
            // any nonzero level pattern keeps the hold count going
            repeat (cfg.cancel_hold_ticks + 2) begin
               s = 1'($urandom_range(0, 1));
               queue_levels(s, s ? 1'($urandom_range(0, 1)) : 1'b1, 1);
            end
         end
         default: queue_noise();
      endcase
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (level_q.size() != 0 || req_bus.valid || timer_out_q.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.button_short = 1'b0;
      req_bus.button_long  = 1'b0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = REG_TICKS_PER_SECOND;
      csr_bus.data         = '0;
      cfg.ticks_per_second  = 8'd125;
      cfg.led_pulse_ticks   = 8'd2;
      cfg.debounce_ticks    = 8'd2;
      cfg.short_add_seconds = 16'd60;
      cfg.long_add_seconds  = 16'd600;
      cfg.cancel_hold_ticks = 10'd188;
      cfg.holdoff_ticks     = 8'd125;
      tmr         = '0;
      queued      = 0;
      err_count   = 0;
      idle_cycles = 0;
      calm        = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset settings: presses inside and after the debounce window
      queue_levels(1'b0, 1'b0, 1);
      queue_levels(1'b1, 1'b0, 2);
      queue_levels(1'b0, 1'b0, 1);
      queue_levels(1'b0, 1'b1, 1);
      queue_levels(1'b1, 1'b1, 1);
      queue_levels(1'b0, 1'b0, 2);
      wait_drained();

      // extremes: saturating adds, prescaler reload every tick, instant cancel
      write_reg(REG_TICKS_PER_SECOND, 16'd0);
      write_reg(REG_LED_PULSE_TICKS, 16'd0);
      write_reg(REG_DEBOUNCE_TICKS, 16'd0);
      write_reg(REG_SHORT_ADD_SECONDS, 16'hFFFF);
      write_reg(REG_LONG_ADD_SECONDS, 16'hFFFF);
      write_reg(REG_CANCEL_HOLD_TICKS, 16'd1);
      write_reg(REG_HOLDOFF_TICKS, 16'd0);
      write_reg(REG_NONE, 16'hFFFF);
      queue_levels(1'b1, 1'b0, 1);
      queue_levels(1'b0, 1'b0, 1);
      queue_levels(1'b0, 1'b1, 1);
      queue_levels(1'b1, 1'b1, 2);
      queue_levels(1'b0, 1'b0, 2);
      wait_drained();

      // arming with zero seconds ends in an alarm once the holdoff is over
      write_reg(REG_SHORT_ADD_SECONDS, 16'd0);
      write_reg(REG_LONG_ADD_SECONDS, 16'd0);
      write_reg(REG_HOLDOFF_TICKS, 16'd2);
      write_reg(REG_TICKS_PER_SECOND, 16'd1);
      write_reg(REG_LED_PULSE_TICKS, 16'd1);
      write_reg(REG_DEBOUNCE_TICKS, 16'd1);
      write_reg(REG_CANCEL_HOLD_TICKS, 16'd1023);
      queue_levels(1'b0, 1'b1, 1);
      queue_levels(1'b0, 1'b0, 5);
      queue_levels(1'b1, 1'b0, 1);
      queue_levels(1'b0, 1'b0, 1);
      wait_drained();

      while (queued < ITEM_TARGET) begin
         calm = ($urandom_range(0, 3) == 0);
         choose_settings();
         repeat ($urandom_range(2, 5)) begin
            if ($urandom_range(0, 4) == 0) queue_noise();
            else queue_run();
         end
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (err_count == 0 && timer_out_q.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

>>> sim.f
sv/bct_pkg.sv
sv/bct_ifs.sv
sv/bct_step.sv
sv/button_countdown_timer_top.sv
sv/bct_checker.sv
dv/tb_top.sv
